// ----- rtl/core/clcf_pkg.sv -----
package clcf_pkg;

  // table geometry
  localparam int LOCK_ENTRIES = 64;
  localparam int IDX_W        = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int SEQ_W        = 32;
  localparam int ID_W         = 6;
  localparam int KIND_W       = 3;
  localparam int ACT_W        = 3;
  localparam int ST_W         = 3;

  // per-lock entry status codes
  localparam logic [ST_W-1:0] ST_NONE      = 3'd0;
  localparam logic [ST_W-1:0] ST_ACQUIRING = 3'd1;
  localparam logic [ST_W-1:0] ST_LOCKED    = 3'd2;
  localparam logic [ST_W-1:0] ST_FREE      = 3'd3;
  localparam logic [ST_W-1:0] ST_RELEASING = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACQUIRE = 3'd0,
    KIND_REPLY   = 3'd1,
    KIND_RELEASE = 3'd2,
    KIND_REVOKE  = 3'd3,
    KIND_RETRY   = 3'd4
  } kind_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE     = 3'd0,
    ACT_SEND_ACQ = 3'd1,
    ACT_GRANTED  = 3'd2,
    ACT_WAIT     = 3'd3,
    ACT_SEND_REL = 3'd4,
    ACT_ERROR    = 3'd5
  } action_e;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic            grant_seen;
    logic            revoke_pending;
    logic            reply_awaited;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   lock_id;
    logic              reply_ok;
    logic [SEQ_W-1:0]  server_seq;
  } item_t;

  typedef struct packed {
    action_e          action;
    logic [ID_W-1:0]  out_lock_id;
    logic [SEQ_W-1:0] request_seq;
  } result_t;

  // state updates requested by the step logic
  typedef struct packed {
    logic entry_we;
    logic newest_we;
    logic acq_inc;
    logic rel_inc;
  } upd_t;

endpackage

// ----- rtl/core/clcf_in_if.sv -----
interface clcf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [5:0]  lock_id;
  logic        reply_ok;
  logic [31:0] server_seq;

  modport source(output valid, output kind, output lock_id, output reply_ok,
                 output server_seq, input ready);
  modport sink(input valid, input kind, input lock_id, input reply_ok,
               input server_seq, output ready);
endinterface

// ----- rtl/core/clcf_out_if.sv -----
interface clcf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [5:0]  out_lock_id;
  logic [31:0] request_seq;

  modport source(output valid, output action, output out_lock_id,
                 output request_seq, input ready);
  modport sink(input valid, input action, input out_lock_id,
               input request_seq, output ready);
endinterface

// ----- rtl/core/clcf_ram.sv -----
module clcf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/clcf_step.sv -----
module clcf_step (
  input  clcf_pkg::item_t                 item_i,
  input  clcf_pkg::entry_t                entry_i,
  input  logic [clcf_pkg::SEQ_W-1:0]      newest_seq_i,
  input  logic [clcf_pkg::SEQ_W-1:0]      acq_seq_i,
  input  logic [clcf_pkg::SEQ_W-1:0]      rel_seq_i,
  output clcf_pkg::result_t               result_o,
  output clcf_pkg::entry_t                entry_o,
  output clcf_pkg::upd_t                  upd_o
);
  import clcf_pkg::*;

  logic in_range;
  logic newer;
  logic known_kind;

  assign in_range   = 32'(item_i.lock_id) < LOCK_ENTRIES;
  assign newer      = item_i.server_seq > newest_seq_i;
  assign known_kind = item_i.kind <= KIND_RETRY;

  // one message against one entry
  always_comb begin
    result_o.action      = ACT_NONE;
    result_o.out_lock_id = item_i.lock_id;
    result_o.request_seq = '0;
    entry_o              = entry_i;
    upd_o                = '0;

    if (known_kind && !in_range) begin
      result_o.action = ACT_ERROR;
    end else if (known_kind) begin
      upd_o.entry_we = 1'b1;
      unique case (kind_e'(item_i.kind))
        KIND_ACQUIRE: begin
          if (entry_i.status == ST_NONE) begin
            entry_o.status        = ST_ACQUIRING;
            entry_o.reply_awaited = 1'b1;
            result_o.action       = ACT_SEND_ACQ;
            result_o.request_seq  = acq_seq_i;
            upd_o.acq_inc         = 1'b1;
          end else if (entry_i.status == ST_FREE) begin
            entry_o.status  = ST_LOCKED;
            result_o.action = ACT_GRANTED;
          end else if (entry_i.status == ST_ACQUIRING && entry_i.grant_seen &&
                       !entry_i.reply_awaited) begin
            entry_o.grant_seen     = 1'b0;
            entry_o.revoke_pending = 1'b0;
            entry_o.status         = entry_i.revoke_pending ? ST_RELEASING : ST_LOCKED;
            result_o.action        = ACT_GRANTED;
          end else begin
            result_o.action = ACT_WAIT;
          end
        end
        KIND_REPLY: begin
          if (entry_i.status == ST_ACQUIRING && entry_i.reply_awaited) begin
            entry_o.reply_awaited = 1'b0;
            if (item_i.reply_ok) begin
              entry_o.grant_seen = 1'b1;
            end
          end else begin
            result_o.action = ACT_ERROR;
          end
        end
        KIND_RELEASE: begin
          if (entry_i.status == ST_LOCKED) begin
            entry_o.status = ST_FREE;
          end else if (entry_i.status == ST_RELEASING) begin
            entry_o.status       = ST_NONE;
            result_o.action      = ACT_SEND_REL;
            result_o.request_seq = rel_seq_i;
            upd_o.rel_inc        = 1'b1;
          end else begin
            result_o.action = ACT_ERROR;
          end
        end
        KIND_REVOKE: begin
          if (!newer) begin
            result_o.action = ACT_NONE;
          end else if (entry_i.status == ST_ACQUIRING) begin
            upd_o.newest_we        = 1'b1;
            entry_o.revoke_pending = 1'b1;
          end else if (entry_i.status == ST_FREE) begin
            upd_o.newest_we      = 1'b1;
            entry_o.status       = ST_NONE;
            result_o.action      = ACT_SEND_REL;
            result_o.request_seq = rel_seq_i;
            upd_o.rel_inc        = 1'b1;
          end else if (entry_i.status == ST_LOCKED) begin
            upd_o.newest_we = 1'b1;
            entry_o.status  = ST_RELEASING;
          end else begin
            result_o.action = ACT_ERROR;
          end
        end
        KIND_RETRY: begin
          if (!newer) begin
            result_o.action = ACT_NONE;
          end else if (entry_i.status == ST_ACQUIRING) begin
            upd_o.newest_we    = 1'b1;
            entry_o.grant_seen = 1'b1;
          end else begin
            result_o.action = ACT_ERROR;
          end
        end
        default: begin
          upd_o.entry_we = 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/caching_lock_client_fsm_top.sv -----
// the input stage registers the message and its table read; the result register holds the result
// throughput: one message per cycle while out_o is ready; one table read, at most one write per message
// the lock table is a 64-entry ram with a one-entry write bypass
// reset: all locks read as none with clear marks (per-entry valid bits),
// newest server sequence 0, acquire and release sequences start at 1
module caching_lock_client_fsm_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  clcf_in_if.sink  in_i,
  clcf_out_if.source out_o
);
  import clcf_pkg::*;

  logic                    accept;
  logic                    s1_fire;
  logic                    s1_vld_q;
  item_t                   item_q;
  logic                    byp_hit_q;
  entry_t                  byp_q;
  logic [LOCK_ENTRIES-1:0] vld_q;
  logic [SEQ_W-1:0]        newest_q;
  logic [SEQ_W-1:0]        acq_seq_q;
  logic [SEQ_W-1:0]        rel_seq_q;
  logic                    out_vld_q;
  result_t                 res_q;

  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        wr_addr;
  logic                    wr_en;
  logic [ENTRY_W-1:0]      rdata;
  entry_t                  entry_cur;
  entry_t                  entry_nxt;
  result_t                 res;
  upd_t                    upd;

  // handshake
  assign s1_fire    = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_fire;
  assign accept     = in_i.valid && in_i.ready;

  assign rd_addr = IDX_W'(in_i.lock_id);
  assign wr_addr = IDX_W'(item_q.lock_id);
  assign wr_en   = s1_fire && upd.entry_we;

  // lock table
  clcf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(LOCK_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(entry_nxt),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  // entry seen by the current message: bypass, table, or reset value
  always_comb begin
    if (byp_hit_q) begin
      entry_cur = byp_q;
    end else if (vld_q[wr_addr]) begin
      entry_cur = entry_t'(rdata);
    end else begin
      entry_cur = '0;
    end
  end

  clcf_step u_step (
    .item_i      (item_q),
    .entry_i     (entry_cur),
    .newest_seq_i(newest_q),
    .acq_seq_i   (acq_seq_q),
    .rel_seq_i   (rel_seq_q),
    .result_o    (res),
    .entry_o     (entry_nxt),
    .upd_o       (upd)
  );

  // input stage and write bypass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      byp_hit_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_q  <= 1'b1;
        byp_hit_q <= wr_en && (wr_addr == rd_addr);
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind       <= in_i.kind;
      item_q.lock_id    <= in_i.lock_id;
      item_q.reply_ok   <= in_i.reply_ok;
      item_q.server_seq <= in_i.server_seq;
      byp_q             <= entry_nxt;
    end
  end

  // entry valid bits and sequence counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      newest_q  <= '0;
      acq_seq_q <= SEQ_W'(1);
      rel_seq_q <= SEQ_W'(1);
    end else if (s1_fire) begin
      if (upd.entry_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (upd.newest_we) begin
        newest_q <= item_q.server_seq;
      end
      if (upd.acq_inc) begin
        acq_seq_q <= acq_seq_q + SEQ_W'(1);
      end
      if (upd.rel_inc) begin
        rel_seq_q <= rel_seq_q + SEQ_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.action      = res_q.action;
  assign out_o.out_lock_id = res_q.out_lock_id;
  assign out_o.request_seq = res_q.request_seq;

endmodule

// ----- dv/caching_lock_client_fsm_top_tb.sv -----
module caching_lock_client_fsm_top_tb;
  import clcf_pkg::*;

  // kinds outside the protocol, ignored by the block
  localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;
  localparam logic [SEQ_W-1:0]  SEQ_MAX    = '1;
  localparam int                N_DIRECTED = 23;
  localparam int                N_RANDOM   = 1650;
  localparam int                HOLD_AFTER = 400;
  localparam int                HOLD_SPAN  = 300;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   lock_id;
    logic              reply_ok;
    logic [SEQ_W-1:0]  server_seq;
    logic              fixed;
    action_e           action;
    logic [SEQ_W-1:0]  request_seq;
  } lock_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  clcf_in_if  in_if ();
  clcf_out_if out_if ();

  caching_lock_client_fsm_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  // local copy of the lock table
  logic [ST_W-1:0]  cache_status [LOCK_ENTRIES];
  logic             cache_grant  [LOCK_ENTRIES];
  logic             cache_revoke [LOCK_ENTRIES];
  logic             cache_reply  [LOCK_ENTRIES];
  logic [SEQ_W-1:0] cache_newest_seq;
  logic [SEQ_W-1:0] cache_acq_seq;
  logic [SEQ_W-1:0] cache_rel_seq;

  result_t   pending_actions [$];
  lock_row_t directed_rows [N_DIRECTED];
  int        fail_count   = 0;
  int        actions_seen = 0;
  bit        hold_done    = 1'b0;

  // next action of the lock cache for one message, updating the local table
  function automatic result_t lock_cache_step(item_t it);
    result_t          res;
    logic [ST_W-1:0]  st;
    logic [ID_W-1:0]  id;
    id              = it.lock_id;
    st              = cache_status[id];
    res.action      = ACT_NONE;
    res.out_lock_id = id;
    res.request_seq = '0;
    if (it.kind > KIND_RETRY) begin
      res.action = ACT_NONE;
    end else if (int'(id) >= LOCK_ENTRIES) begin
      res.action = ACT_ERROR;
    end else begin
      case (it.kind)
        KIND_ACQUIRE: begin
          if (st == ST_NONE) begin
            cache_status[id] = ST_ACQUIRING;
            cache_reply[id]  = 1'b1;
            res.action       = ACT_SEND_ACQ;
            res.request_seq  = cache_acq_seq;
            cache_acq_seq    = cache_acq_seq + SEQ_W'(1);
          end else if (st == ST_FREE) begin
            cache_status[id] = ST_LOCKED;
            res.action       = ACT_GRANTED;
          end else if (st == ST_ACQUIRING && cache_grant[id] && !cache_reply[id]) begin
            cache_grant[id]  = 1'b0;
            cache_status[id] = cache_revoke[id] ? ST_RELEASING : ST_LOCKED;
            cache_revoke[id] = 1'b0;
            res.action       = ACT_GRANTED;
          end else begin
            res.action = ACT_WAIT;
          end
        end
        KIND_REPLY: begin
          if (st == ST_ACQUIRING && cache_reply[id]) begin
            cache_reply[id] = 1'b0;
            if (it.reply_ok) cache_grant[id] = 1'b1;
          end else begin
            res.action = ACT_ERROR;
          end
        end
        KIND_RELEASE: begin
          if (st == ST_LOCKED) begin
            cache_status[id] = ST_FREE;
          end else if (st == ST_RELEASING) begin
            cache_status[id] = ST_NONE;
            res.action       = ACT_SEND_REL;
            res.request_seq  = cache_rel_seq;
            cache_rel_seq    = cache_rel_seq + SEQ_W'(1);
          end else begin
            res.action = ACT_ERROR;
          end
        end
        KIND_REVOKE: begin
          // stale sequence numbers are dropped silently
          if (it.server_seq <= cache_newest_seq) begin
            res.action = ACT_NONE;
          end else if (st == ST_ACQUIRING) begin
            cache_newest_seq = it.server_seq;
            cache_revoke[id] = 1'b1;
          end else if (st == ST_FREE) begin
            cache_newest_seq = it.server_seq;
            cache_status[id] = ST_NONE;
            res.action       = ACT_SEND_REL;
            res.request_seq  = cache_rel_seq;
            cache_rel_seq    = cache_rel_seq + SEQ_W'(1);
          end else if (st == ST_LOCKED) begin
            cache_newest_seq = it.server_seq;
            cache_status[id] = ST_RELEASING;
          end else begin
            res.action = ACT_ERROR;
          end
        end
        KIND_RETRY: begin
          if (it.server_seq <= cache_newest_seq) begin
            res.action = ACT_NONE;
          end else if (st == ST_ACQUIRING) begin
            cache_newest_seq = it.server_seq;
            cache_grant[id]  = 1'b1;
          end else begin
            res.action = ACT_ERROR;
          end
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // mostly the message that fits the entry's state, some out-of-turn noise
  function automatic item_t pick_lock_message();
    item_t            it;
    logic [ST_W-1:0]  st;
    logic [SEQ_W-1:0] fresh_seq;
    logic [SEQ_W-1:0] stale_seq;
    int               r;
    if ($urandom_range(0, 9) < 6) it.lock_id = ID_W'($urandom_range(0, 7));
    else it.lock_id = ID_W'($urandom_range(0, 63));
    st          = cache_status[it.lock_id];
    fresh_seq   = cache_newest_seq + SEQ_W'($urandom_range(1, 64));
    stale_seq   = SEQ_W'($urandom_range(0, cache_newest_seq));
    it.reply_ok = ($urandom_range(0, 3) != 0);
    r           = $urandom_range(0, 5);
    if ($urandom_range(0, 99) < 15) begin
      it.kind = KIND_W'($urandom_range(0, 7));
      // a wide sequence only where it cannot be taken
      if (st == ST_NONE) it.server_seq = $urandom;
      else it.server_seq = r[0] ? fresh_seq : stale_seq;
    end else begin
      it.server_seq = ($urandom_range(0, 99) < 85) ? fresh_seq : stale_seq;
      case (st)
        ST_NONE: it.kind = KIND_ACQUIRE;
        ST_ACQUIRING: begin
          if (cache_reply[it.lock_id]) begin
            if (r <= 2) it.kind = KIND_REPLY;
            else if (r == 3) it.kind = KIND_ACQUIRE;
            else if (r == 4) it.kind = KIND_REVOKE;
            else it.kind = KIND_RETRY;
          end else if (cache_grant[it.lock_id]) begin
            it.kind = (r <= 3) ? KIND_ACQUIRE : KIND_REVOKE;
          end else begin
            it.kind = (r <= 3) ? KIND_RETRY : KIND_ACQUIRE;
          end
        end
        ST_LOCKED:    it.kind = (r <= 3) ? KIND_RELEASE : KIND_REVOKE;
        ST_FREE:      it.kind = (r <= 2) ? KIND_ACQUIRE : KIND_REVOKE;
        ST_RELEASING: it.kind = (r <= 3) ? KIND_RELEASE : KIND_ACQUIRE;
        default:      it.kind = KIND_ACQUIRE;
      endcase
    end
    return it;
  endfunction

  // offer one message, wait for the transfer, then record its action
  task automatic offer_message(item_t it, int gap, logic fixed, result_t fixed_res);
    result_t res;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= it.kind;
    in_if.lock_id    <= it.lock_id;
    in_if.reply_ok   <= it.reply_ok;
    in_if.server_seq <= it.server_seq;
    do @(posedge clk_i); while (!in_if.ready);
    res = lock_cache_step(it);
    pending_actions.push_back(fixed ? fixed_res : res);
  endtask

  // reset, directed table, random traffic, drain
  initial begin
    item_t   it;
    result_t fixed_res;
    int      gap;
    in_if.valid      <= 1'b0;
    in_if.kind       <= KIND_ACQUIRE;
    in_if.lock_id    <= '0;
    in_if.reply_ok   <= 1'b0;
    in_if.server_seq <= '0;
    for (int i = 0; i < LOCK_ENTRIES; i++) begin
      cache_status[i] = ST_NONE;
      cache_grant[i]  = 1'b0;
      cache_revoke[i] = 1'b0;
      cache_reply[i]  = 1'b0;
    end
    cache_newest_seq = '0;
    cache_acq_seq    = 32'd1;
    cache_rel_seq    = 32'd1;

    directed_rows = '{
      // fresh lock: acquire, grant, use, then revoked while free
      '{KIND_ACQUIRE, 6'd0,  1'b0, 32'd0,   1'b1, ACT_SEND_ACQ, 32'd1},
      '{KIND_REPLY,   6'd0,  1'b1, 32'd0,   1'b1, ACT_NONE,     32'd0},
      '{KIND_ACQUIRE, 6'd0,  1'b0, 32'd0,   1'b1, ACT_GRANTED,  32'd0},
      '{KIND_RELEASE, 6'd0,  1'b0, 32'd0,   1'b1, ACT_NONE,     32'd0},
      '{KIND_REVOKE,  6'd0,  1'b0, 32'd5,   1'b1, ACT_SEND_REL, 32'd1},
      // messages in the wrong state
      '{KIND_RELEASE, 6'd0,  1'b0, 32'd0,   1'b1, ACT_ERROR,    32'd0},
      '{KIND_REPLY,   6'd0,  1'b0, 32'd0,   1'b1, ACT_ERROR,    32'd0},
      '{KIND_REVOKE,  6'd63, 1'b1, SEQ_MAX, 1'b1, ACT_ERROR,    32'd0},
      '{KIND_RETRY,   6'd63, 1'b1, SEQ_MAX, 1'b1, ACT_ERROR,    32'd0},
      // stale revoke
      '{KIND_REVOKE,  6'd0,  1'b0, 32'd0,   1'b1, ACT_NONE,     32'd0},
      // retry path with a revoke arriving during the acquire
      '{KIND_ACQUIRE, 6'd63, 1'b0, 32'd0,   1'b0, ACT_NONE,     32'd0},
      '{KIND_ACQUIRE, 6'd63, 1'b0, 32'd0,   1'b0, ACT_NONE,     32'd0},
      '{KIND_REPLY,   6'd63, 1'b0, 32'd0,   1'b0, ACT_NONE,     32'd0},
      '{KIND_ACQUIRE, 6'd63, 1'b0, 32'd0,   1'b0, ACT_NONE,     32'd0},
      '{KIND_RETRY,   6'd63, 1'b0, 32'd3,   1'b0, ACT_NONE,     32'd0},
      '{KIND_RETRY,   6'd63, 1'b0, 32'd6,   1'b0, ACT_NONE,     32'd0},
      '{KIND_REVOKE,  6'd63, 1'b0, 32'd7,   1'b0, ACT_NONE,     32'd0},
      '{KIND_ACQUIRE, 6'd63, 1'b0, 32'd0,   1'b0, ACT_NONE,     32'd0},
      '{KIND_ACQUIRE, 6'd63, 1'b0, 32'd0,   1'b0, ACT_NONE,     32'd0},
      '{KIND_RELEASE, 6'd63, 1'b0, 32'd0,   1'b0, ACT_NONE,     32'd0},
      // reserved kinds are ignored
      '{KIND_RSVD7,   6'd42, 1'b1, SEQ_MAX, 1'b1, ACT_NONE,     32'd0},
      '{KIND_RSVD5,   6'd21, 1'b0, 32'd0,   1'b1, ACT_NONE,     32'd0},
      '{KIND_RSVD6,   6'd1,  1'b1, 32'd9,   1'b1, ACT_NONE,     32'd0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      it.kind               = directed_rows[i].kind;
      it.lock_id            = directed_rows[i].lock_id;
      it.reply_ok           = directed_rows[i].reply_ok;
      it.server_seq         = directed_rows[i].server_seq;
      fixed_res.action      = directed_rows[i].action;
      fixed_res.out_lock_id = directed_rows[i].lock_id;
      fixed_res.request_seq = directed_rows[i].request_seq;
      offer_message(it, idle_span(), directed_rows[i].fixed, fixed_res);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      it  = pick_lock_message();
      // back-to-back bursts every so often
      gap = ((n / 150) % 4 == 1) ? 0 : idle_span();
      offer_message(it, gap, 1'b0, fixed_res);
    end
    in_if.valid <= 1'b0;

    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("caching_lock_client_fsm_top test passed");
    end else begin
      $display("caching_lock_client_fsm_top test failed");
    end
    $finish;
  end

  // result side ready: random stalls plus one long hold-off
  initial begin
    int run;
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!hold_done && actions_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_SPAN) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      repeat (run) @(posedge clk_i);
      stall = idle_span();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // compare each result transfer with the oldest pending action
  always @(posedge clk_i) begin
    result_t want;
    if (out_if.valid && out_if.ready) begin
      actions_seen++;
      if (pending_actions.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result action=%0d lock=%0d seq=%0h", $time,
                 out_if.action, out_if.out_lock_id, out_if.request_seq);
      end else begin
        want = pending_actions.pop_front();
        if (out_if.action !== want.action) begin
          fail_count++;
          $display("%0t: action expected %0d got %0d", $time, want.action, out_if.action);
        end
        if (out_if.out_lock_id !== want.out_lock_id) begin
          fail_count++;
          $display("%0t: lock id expected %0d got %0d", $time, want.out_lock_id,
                   out_if.out_lock_id);
        end
        if (out_if.request_seq !== want.request_seq) begin
          fail_count++;
          $display("%0t: request seq expected %0h got %0h", $time, want.request_seq,
                   out_if.request_seq);
        end
      end
    end
  end

  // watchdog
  initial begin
    #1500000;
    $display("caching_lock_client_fsm_top test failed");
    $finish;
  end

endmodule
